FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: item payloads,
// request codes, microcode control word and datapath status flags.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Request codes carried in req_type.
   localparam logic [1:0] REQ_PUT  = 2'd0;
   localparam logic [1:0] REQ_BACK = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_TEXT_ATTR  = 1'b0;
   localparam logic CSR_ERASE_ATTR = 1'b1;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'd32;
   localparam logic [7:0] TEXT_ATTR_RESET  = 8'd15;
   localparam logic [7:0] ERASE_ATTR_RESET = 8'd13;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } req_item_type;

   typedef struct packed {
      logic [10:0] cursor_pos;
      logic [7:0]  cell_char;
      logic [7:0]  cell_attr;
   } rsp_item_type;

   // Microprogram step addresses.
   typedef enum logic [3:0] {
      S_CLEAR    = 4'd0,
      S_IDLE     = 4'd1,
      S_PUT      = 4'd2,
      S_PUT_WR   = 4'd3,
      S_NL       = 4'd4,
      S_SC_RD    = 4'd5,
      S_SC_WR    = 4'd6,
      S_SC_BLANK = 4'd7,
      S_BS       = 4'd8,
      S_BS_WR    = 4'd9,
      S_READ     = 4'd10,
      S_RESP     = 4'd11,
      S_RESP_RD  = 4'd12
   } step_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_ZERO,
      WR_TEXT,
      WR_ERASE,
      WR_COPY,
      WR_BLANK
   } wr_sel_type;

   typedef enum logic {
      RD_IDX,
      RD_SHIFT
   } rd_sel_type;

   typedef enum logic [1:0] {
      P_HOLD,
      P_INC,
      P_CLEAR
   } ptr_op_type;

   typedef enum logic [1:0] {
      C_HOLD,
      C_ADV,
      C_NEWROW,
      C_BACK
   } cur_op_type;

   typedef enum logic [3:0] {
      CND_ALWAYS,
      CND_REQ,
      CND_NEWLINE,
      CND_COL_LAST,
      CND_ROW_LAST,
      CND_ROW_ZERO,
      CND_PTR_TOP,
      CND_PTR_LAST,
      CND_RSP_FREE
   } cond_type;

   typedef struct packed {
      wr_sel_type wr_sel;
      rd_sel_type rd_sel;
      ptr_op_type ptr_op;
      cur_op_type cur_op;
      cond_type   cond;
      step_type   jmp_t;
      step_type   jmp_f;
      logic       accept;
      logic       dispatch;
      logic       respond;
      logic       from_ram;
   } ctl_word_type;

   typedef struct packed {
      logic req_valid;
      logic newline;
      logic col_last;
      logic row_last;
      logic row_zero;
      logic ptr_top;
      logic ptr_last;
      logic rsp_free;
   } flags_type;

endpackage

FILE: rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tcw_useq.sv
// ----------------------------------------------------------------------------
// tcw_useq
// Microcode sequencer: step counter, control store and jump logic. Each
// step's control word drives the datapath and picks the next step.
// ----------------------------------------------------------------------------
module tcw_useq (
   input  logic                  clock,
   input  logic                  reset,
   input  tcw_pkg::flags_type    flags,
   input  logic [1:0]            new_req_type,
   output tcw_pkg::ctl_word_type ctl
);

   import tcw_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     cond_true;

   function automatic ctl_word_type ucode(input step_type step);
      ctl_word_type w;
      w = '{wr_sel: WR_NONE, rd_sel: RD_IDX, ptr_op: P_HOLD, cur_op: C_HOLD,
            cond: CND_ALWAYS, jmp_t: S_IDLE, jmp_f: S_IDLE, accept: 1'b0,
            dispatch: 1'b0, respond: 1'b0, from_ram: 1'b0};
      case (step)
         S_CLEAR: begin
            w.wr_sel = WR_ZERO;
            w.ptr_op = P_INC;
            w.cond   = CND_PTR_LAST;
            w.jmp_t  = S_IDLE;
            w.jmp_f  = S_CLEAR;
         end
         S_IDLE: begin
            w.accept   = 1'b1;
            w.dispatch = 1'b1;
            w.cond     = CND_REQ;
            w.jmp_f    = S_IDLE;
         end
         S_PUT: begin
            w.cond  = CND_NEWLINE;
            w.jmp_t = S_NL;
            w.jmp_f = S_PUT_WR;
         end
         S_PUT_WR: begin
            w.wr_sel = WR_TEXT;
            w.cur_op = C_ADV;
            w.cond   = CND_COL_LAST;
            w.jmp_t  = S_NL;
            w.jmp_f  = S_RESP;
         end
         S_NL: begin
            w.cur_op = C_NEWROW;
            w.ptr_op = P_CLEAR;
            w.cond   = CND_ROW_LAST;
            w.jmp_t  = S_SC_RD;
            w.jmp_f  = S_RESP;
         end
         S_SC_RD: begin
            w.rd_sel = RD_SHIFT;
            w.jmp_t  = S_SC_WR;
         end
         S_SC_WR: begin
            w.wr_sel = WR_COPY;
            w.ptr_op = P_INC;
            w.cond   = CND_PTR_TOP;
            w.jmp_t  = S_SC_BLANK;
            w.jmp_f  = S_SC_RD;
         end
         S_SC_BLANK: begin
            w.wr_sel = WR_BLANK;
            w.ptr_op = P_INC;
            w.cond   = CND_PTR_LAST;
            w.jmp_t  = S_RESP;
            w.jmp_f  = S_SC_BLANK;
         end
         S_BS: begin
            w.cur_op = C_BACK;
            w.cond   = CND_ROW_ZERO;
            w.jmp_t  = S_RESP;
            w.jmp_f  = S_BS_WR;
         end
         S_BS_WR: begin
            w.wr_sel = WR_ERASE;
            w.jmp_t  = S_RESP;
         end
         S_READ: begin
            w.rd_sel = RD_IDX;
            w.jmp_t  = S_RESP_RD;
         end
         S_RESP: begin
            w.respond = 1'b1;
            w.cond    = CND_RSP_FREE;
            w.jmp_t   = S_IDLE;
            w.jmp_f   = S_RESP;
         end
         S_RESP_RD: begin
            w.rd_sel   = RD_IDX;
            w.respond  = 1'b1;
            w.from_ram = 1'b1;
            w.cond     = CND_RSP_FREE;
            w.jmp_t    = S_IDLE;
            w.jmp_f    = S_RESP_RD;
         end
         default: begin
            w.jmp_t = S_IDLE;
         end
      endcase
      return w;
   endfunction

   assign ctl = ucode(step_ff);

   always_comb begin
      case (ctl.cond)
         CND_ALWAYS:   cond_true = 1'b1;
         CND_REQ:      cond_true = flags.req_valid;
         CND_NEWLINE:  cond_true = flags.newline;
         CND_COL_LAST: cond_true = flags.col_last;
         CND_ROW_LAST: cond_true = flags.row_last;
         CND_ROW_ZERO: cond_true = flags.row_zero;
         CND_PTR_TOP:  cond_true = flags.ptr_top;
         CND_PTR_LAST: cond_true = flags.ptr_last;
         CND_RSP_FREE: cond_true = flags.rsp_free;
         default:      cond_true = 1'b1;
      endcase

      if (!cond_true) begin
         step_in = ctl.jmp_f;
      end else if (ctl.dispatch) begin
         case (new_req_type)
            REQ_PUT:  step_in = S_PUT;
            REQ_BACK: step_in = S_BS;
            REQ_READ: step_in = S_READ;
            default:  step_in = S_RESP;
         endcase
      end else begin
         step_in = ctl.jmp_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

FILE: rtl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen stores, cursor, sweep pointer and result register, steered by the
// current control word, and attribute registers set through the csr port.
// ----------------------------------------------------------------------------
module tcw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tcw_pkg::ctl_word_type ctl,
   input  logic                  req_valid,
   input  tcw_pkg::req_item_type req_data,
   output tcw_pkg::flags_type    flags,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tcw_pkg::rsp_item_type rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata
);

   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int CMP_W = ((AW > 11) ? AW : 11) + 1;

   req_item_type req_ff;
   logic [7:0]   text_attr_ff;
   logic [7:0]   erase_attr_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          rsp_valid_ff;
   rsp_item_type  rsp_ff;

   logic          rsp_load;
   logic          in_range;
   logic          char_we, attr_we;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    char_wdata, attr_wdata;
   logic [7:0]    char_rdata, attr_rdata;

   assign in_range = (CMP_W'(req_ff.cell_index) < CMP_W'(CELLS));

   assign flags.req_valid = req_valid;
   assign flags.newline   = (req_ff.char_code == NEWLINE_CODE);
   assign flags.col_last  = (col_ff == CW'(COLUMNS - 1));
   assign flags.row_last  = (row_ff == RW'(ROWS - 1));
   assign flags.row_zero  = (row_ff == '0);
   assign flags.ptr_top   = (ptr_ff == AW'(CELLS - COLUMNS - 1));
   assign flags.ptr_last  = (ptr_ff == AW'(CELLS - 1));
   assign flags.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_load = ctl.respond && flags.rsp_free;

   // Store port steering.
   always_comb begin
      char_we    = 1'b0;
      attr_we    = 1'b0;
      wr_addr    = cur_ff;
      char_wdata = 8'd0;
      attr_wdata = 8'd0;
      case (ctl.wr_sel)
         WR_ZERO: begin
            char_we = 1'b1;
            attr_we = 1'b1;
            wr_addr = ptr_ff;
         end
         WR_TEXT: begin
            char_we    = 1'b1;
            attr_we    = 1'b1;
            char_wdata = req_ff.char_code;
            attr_wdata = text_attr_ff;
         end
         WR_ERASE: begin
            char_we    = 1'b1;
            attr_we    = 1'b1;
            char_wdata = SPACE_CODE;
            attr_wdata = erase_attr_ff;
         end
         WR_COPY: begin
            char_we    = 1'b1;
            attr_we    = 1'b1;
            wr_addr    = ptr_ff;
            char_wdata = char_rdata;
            attr_wdata = attr_rdata;
         end
         WR_BLANK: begin
            // The bottom row keeps its attributes after a scroll.
            char_we    = 1'b1;
            wr_addr    = ptr_ff;
            char_wdata = SPACE_CODE;
         end
         default: begin
            char_we = 1'b0;
         end
      endcase

      case (ctl.rd_sel)
         RD_SHIFT: rd_addr = AW'(ptr_ff + AW'(COLUMNS));
         default:  rd_addr = AW'(req_ff.cell_index);
      endcase
   end

   tcw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
      .clock   (clock),
      .wr_en   (char_we),
      .wr_addr (wr_addr),
      .wr_data (char_wdata),
      .rd_addr (rd_addr),
      .rd_data (char_rdata)
   );

   tcw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_attr_ram (
      .clock   (clock),
      .wr_en   (attr_we),
      .wr_addr (wr_addr),
      .wr_data (attr_wdata),
      .rd_addr (rd_addr),
      .rd_data (attr_rdata)
   );

   // Cursor moves. The linear position is kept alongside row and column so
   // that no multiply is needed.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      cur_in = cur_ff;
      case (ctl.cur_op)
         C_ADV: begin
            // At the last column the wrap is left to the new-row step.
            if (!flags.col_last) begin
               col_in = CW'(col_ff + 1'b1);
               cur_in = AW'(cur_ff + 1'b1);
            end
         end
         C_NEWROW: begin
            col_in = '0;
            if (flags.row_last) begin
               cur_in = AW'(CELLS - COLUMNS);
            end else begin
               row_in = RW'(row_ff + 1'b1);
               cur_in = AW'(cur_ff - AW'(col_ff) + AW'(COLUMNS));
            end
         end
         C_BACK: begin
            if (!flags.row_zero) begin
               cur_in = AW'(cur_ff - 1'b1);
               if (col_ff == '0) begin
                  col_in = CW'(COLUMNS - 1);
                  row_in = RW'(row_ff - 1'b1);
               end else begin
                  col_in = CW'(col_ff - 1'b1);
               end
            end
         end
         default: begin
            col_in = col_ff;
         end
      endcase

      case (ctl.ptr_op)
         P_INC:   ptr_in = AW'(ptr_ff + 1'b1);
         P_CLEAR: ptr_in = '0;
         default: ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         cur_ff        <= '0;
         ptr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         text_attr_ff  <= TEXT_ATTR_RESET;
         erase_attr_ff <= ERASE_ATTR_RESET;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         cur_ff <= cur_in;
         ptr_ff <= ptr_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_TEXT_ATTR:  text_attr_ff  <= csr_wdata;
               CSR_ERASE_ATTR: erase_attr_ff <= csr_wdata;
               default:        text_attr_ff  <= text_attr_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept && req_valid) begin
         req_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_ff.cursor_pos <= 11'(cur_ff);
         if (ctl.from_ram && in_range) begin
            rsp_ff.cell_char <= char_rdata;
            rsp_ff.cell_attr <= attr_rdata;
         end else begin
            rsp_ff.cell_char <= 8'd0;
            rsp_ff.cell_attr <= 8'd0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: character and attribute screen stores with a
// cursor, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Steps from the accepting idle step to the result step: a read uses the read
// step, a put the put and write steps, a newline the put and new-row steps, a
// put that fills a row all three, a backspace the back and erase steps (back
// only on the top row); a scroll adds a read and a write step per moved cell
// and one step per blanked cell. Items are taken only in the idle step.
// Reset: synchronous; a clearing pass over every cell then holds off items.
module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tcw_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tcw_pkg::rsp_item_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata
);

   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CMP_W = ((AW > 11) ? AW : 11) + 1;

   ctl_word_type ctl;
   flags_type    flags;

   assign req_stall = !ctl.accept;
   assign csr_ready = 1'b1;

   tcw_useq u_useq (
      .clock        (clock),
      .reset        (reset),
      .flags        (flags),
      .new_req_type (req_data.req_type),
      .ctl          (ctl)
   );

   tcw_datapath #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_valid (req_valid),
      .req_data  (req_data),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

`ifndef SYNTHESIS
   // An accepted item always leaves the idle step, so two accepts never
   // come back to back.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted in the cycle after an accept");

   // A result step with a free output register must load it.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (ctl.respond && flags.rsp_free) |=> rsp_valid)
      else $error("result step did not load the output register");

   // The reported cursor always lies on the screen.
   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CMP_W'(rsp_data.cursor_pos) < CMP_W'(CELLS)))
      else $error("cursor position beyond the screen");
`endif

endmodule

FILE: tb/tb_text_console_writer.sv
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the text console writer. A queue of requests feeds
// a bursty driver. A shadow screen, cursor and pair of attribute registers
// predict every reply. Another process checks the replies field by field
// while it stalls on its own pattern. The run starts with the reset
// attributes and then steps through several attribute settings.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
   timeunit 1ns;
   timeprecision 1ps;

   import tcw_pkg::*;

   localparam int SCREEN_COLS  = 80;
   localparam int SCREEN_ROWS  = 25;
   localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
   localparam int HOLD_CYCLES  = 300;

   // The block ignores this request code apart from reporting the cursor.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY
   } stall_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = CSR_TEXT_ATTR;
   logic [7:0]   csr_wdata = '0;

   // Shadow of the console.
   logic [7:0]  shadow_chars [SCREEN_CELLS];
   logic [7:0]  shadow_attrs [SCREEN_CELLS];
   int unsigned cur_col;
   int unsigned cur_row;
   logic [7:0]  text_attr_q  = TEXT_ATTR_RESET;
   logic [7:0]  erase_attr_q = ERASE_ATTR_RESET;

   req_item_type pending_reqs[$];
   rsp_item_type expected_replies[$];

   int unsigned queued_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned checked_count  = 0;
   int unsigned scroll_count   = 0;
   int unsigned setting_count  = 0;
   int unsigned fault_count    = 0;
   longint unsigned cycle_count = 0;
   longint unsigned cycle_limit = 50_000;

   int unsigned    burst_left = 0;
   int unsigned    gap_left   = 0;
   bit             hold_request = 1'b0;
   int unsigned    hold_left = 0;
   int unsigned    mode_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   text_console_writer #(
      .COLUMNS(SCREEN_COLS),
      .ROWS   (SCREEN_ROWS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Moving below the last row shifts every row up and blanks the bottom
   // row's characters; its attributes are left alone.
   function automatic void move_to_next_row();
      cur_col = 0;
      if (cur_row == SCREEN_ROWS - 1) begin
         for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++) begin
            shadow_chars[i] = shadow_chars[i + SCREEN_COLS];
            shadow_attrs[i] = shadow_attrs[i + SCREEN_COLS];
         end
         for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
            shadow_chars[i] = SPACE_CODE;
         scroll_count++;
      end else begin
         cur_row++;
      end
   endfunction

   function automatic rsp_item_type advance_console(input req_item_type item);
      rsp_item_type reply;
      int unsigned  at;
      reply = '0;
      case (item.req_type)
         REQ_PUT: begin
            if (item.char_code == NEWLINE_CODE) begin
               move_to_next_row();
            end else begin
               at = cur_row * SCREEN_COLS + cur_col;
               shadow_chars[at] = item.char_code;
               shadow_attrs[at] = text_attr_q;
               cur_col++;
               if (cur_col == SCREEN_COLS)
                  move_to_next_row();
            end
         end
         REQ_BACK: begin
            // The top row never erases anything.
            if (cur_row != 0) begin
               if (cur_col == 0) begin
                  cur_col = SCREEN_COLS;
                  cur_row--;
               end
               cur_col--;
               at = cur_row * SCREEN_COLS + cur_col;
               shadow_chars[at] = SPACE_CODE;
               shadow_attrs[at] = erase_attr_q;
            end
         end
         REQ_READ: begin
            if (item.cell_index < SCREEN_CELLS) begin
               reply.cell_char = shadow_chars[item.cell_index];
               reply.cell_attr = shadow_attrs[item.cell_index];
            end
         end
         default: ;
      endcase
      reply.cursor_pos = 11'(cur_row * SCREEN_COLS + cur_col);
      return reply;
   endfunction

   function automatic void compare_field(input string field, input logic [10:0] want,
                                         input logic [10:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         fault_count++;
      end
   endfunction

   // Driver: bursts of items separated by random gaps.
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_replies.push_back(advance_console(req_data));
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs.pop_front();
               offer = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
            req_valid <= offer;
         end
      end
   end

   // Reply checker with its own stall pattern and an occasional long hold.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $error("reply with nothing outstanding: %h", rsp_data);
               fault_count++;
            end else begin
               want = expected_replies.pop_front();
               compare_field("cursor_pos", want.cursor_pos, rsp_data.cursor_pos);
               compare_field("cell_char", 11'(want.cell_char), 11'(rsp_data.cell_char));
               compare_field("cell_attr", 11'(want.cell_attr), 11'(rsp_data.cell_attr));
               checked_count++;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(16, 160);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               default:     rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $error("no progress after %0d cycles", cycle_count);
         $display("tb_text_console_writer failed");
         $finish;
      end
   end

   // Each request widens the cycle budget; a newline may cost a full scroll.
   task automatic queue_req(input logic [1:0] kind, input logic [7:0] code,
                            input logic [10:0] index);
      req_item_type item;
      item.req_type   = kind;
      item.char_code  = code;
      item.cell_index = index;
      pending_reqs.push_back(item);
      queued_count++;
      cycle_limit += 300;
      if (kind == REQ_PUT)
         cycle_limit += (code == NEWLINE_CODE) ? 12_000 : 150;
   endtask

   // Mostly lines of text ended by a newline, with backspace runs, reads
   // and some fully random requests mixed in.
   task automatic queue_text_traffic(input int unsigned target);
      int unsigned first;
      int unsigned len;
      int unsigned pick;
      first = queued_count;
      while (queued_count - first < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 12);
            repeat (len) queue_req(REQ_PUT, 8'($urandom), 11'($urandom));
            queue_req(REQ_PUT, NEWLINE_CODE, 11'($urandom));
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 6)) queue_req(REQ_BACK, 8'($urandom), 11'($urandom));
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 4))
               queue_req(REQ_READ, 8'($urandom),
                         ($urandom_range(0, 2) == 0) ?
                            11'($urandom_range(SCREEN_CELLS - 2 * SCREEN_COLS, 2047)) :
                            11'($urandom));
         end else begin
            queue_req(2'($urandom), 8'($urandom), 11'($urandom));
         end
      end
   endtask

   task automatic wait_for_drain();
      while (pending_reqs.size() != 0 || req_valid || expected_replies.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Both registers are written back to back; valid stays high in between.
   task automatic write_attrs(input logic [7:0] text_value, input logic [7:0] erase_value);
      csr_valid <= 1'b1;
      csr_index <= CSR_TEXT_ATTR;
      csr_wdata <= text_value;
      do @(posedge clock); while (!csr_ready);
      text_attr_q = text_value;
      csr_index <= CSR_ERASE_ATTR;
      csr_wdata <= erase_value;
      do @(posedge clock); while (!csr_ready);
      erase_attr_q = erase_value;
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   initial begin
      foreach (shadow_chars[i]) begin
         shadow_chars[i] = '0;
         shadow_attrs[i] = '0;
      end
      cur_col = 0;
      cur_row = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the attributes as they come out of reset.
      queue_req(REQ_READ, 8'h00, 11'd0);
      queue_req(REQ_BACK, 8'h00, 11'd0);
      queue_req(REQ_PUT, 8'hFF, 11'h7FF);
      queue_req(REQ_BACK, 8'hFF, 11'h7FF);
      queue_req(REQ_PUT, 8'h00, 11'd0);
      queue_req(REQ_UNUSED, 8'hFF, 11'h7FF);
      queue_req(REQ_READ, 8'h00, 11'd2047);
      queue_req(REQ_READ, 8'h00, 11'(SCREEN_CELLS));
      queue_req(REQ_READ, 8'h00, 11'(SCREEN_CELLS - 1));
      queue_req(REQ_PUT, NEWLINE_CODE, 11'd0);
      // At column zero of row one, backspace wraps to the last cell of row zero;
      // the next character fills that cell and wraps the cursor forward again.
      queue_req(REQ_BACK, 8'h00, 11'd0);
      queue_req(REQ_PUT, 8'h7E, 11'd0);
      queue_req(REQ_READ, 8'h00, 11'(SCREEN_COLS - 1));
      queue_req(REQ_PUT, 8'h41, 11'd0);
      // Walk down to the bottom row and one past it.
      repeat (SCREEN_ROWS - 1) queue_req(REQ_PUT, NEWLINE_CODE, 11'd0);
      queue_req(REQ_READ, 8'h00, 11'd0);
      queue_req(REQ_READ, 8'h00, 11'(SCREEN_CELLS - SCREEN_COLS));
      queue_req(REQ_BACK, 8'h00, 11'd0);
      queue_req(REQ_READ, 8'h00, 11'(SCREEN_CELLS - SCREEN_COLS - 1));
      wait_for_drain();

      write_attrs(8'h00, 8'hFF);
      hold_request = 1'b1;
      cycle_limit += HOLD_CYCLES;
      queue_text_traffic(220);
      wait_for_drain();

      write_attrs(8'hFF, 8'h00);
      queue_text_traffic(220);
      wait_for_drain();

      repeat (3) begin
         write_attrs(8'($urandom), 8'($urandom));
         if (setting_count == 4) begin
            hold_request = 1'b1;
            cycle_limit += HOLD_CYCLES;
         end
         queue_text_traffic(220);
         wait_for_drain();
      end

      repeat (12) @(posedge clock);
      $display("%0d requests accepted, %0d replies checked, %0d scrolls",
               accepted_count, checked_count, scroll_count);
      $display("reset attributes plus %0d written attribute settings", setting_count);
      if (fault_count == 0)
         $display("tb_text_console_writer passed");
      else
         $display("tb_text_console_writer failed");
      $finish;
   end

endmodule
